// File: rtl/upn_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the url path normalizer
package upn_pkg;

   // default store depth in bytes
   localparam int PATH_BYTES_DEF = 512;

   // fixed field widths
   localparam int BYTE_W = 8;
   localparam int ADDR_W = 9;
   localparam int LEN_W  = 9;
   localparam int ERR_W  = 2;

   // characters and two-character patterns
   localparam logic [BYTE_W-1:0]   CH_SLASH      = 8'h2F;
   localparam logic [BYTE_W-1:0]   CH_DOT        = 8'h2E;
   localparam logic [2*BYTE_W-1:0] PAIR_DOTDOT   = {CH_DOT, CH_DOT};
   localparam logic [2*BYTE_W-1:0] PAIR_SLASHDOT = {CH_SLASH, CH_DOT};
   localparam logic [2*BYTE_W-1:0] RECENT_RESET  = {8'h00, CH_SLASH};

   // error codes reported on the terminator word
   typedef enum logic [ERR_W-1:0] {
      ERR_NONE     = 2'd0,
      ERR_NO_SLASH = 2'd1,
      ERR_TOO_LONG = 2'd2
   } err_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_SCAN_REQ,
      ST_SCAN_CHK,
      ST_TAIL_RD1,
      ST_TAIL_RD2,
      ST_TAIL_FIN
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic scan_rd;
      logic scan_chk;
      logic tail_rd1;
      logic tail_rd2;
      logic tail_fin;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic out_free;
      logic need_scan;
      logic last;
      logic scan_hit;
   } status_type;

endpackage

// File: rtl/upn_ctrl.sv
`timescale 1ns / 1ps
// controller state machine of the url path normalizer
module upn_ctrl
   import upn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.need_scan) begin
                  state_in = ST_SCAN_REQ;
               end else if (status.last) begin
                  state_in = ST_TAIL_RD1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN_REQ: begin
            cmd.scan_rd = 1'b1;
            state_in    = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            cmd.scan_chk = 1'b1;
            if (!status.scan_hit) begin
               state_in = ST_SCAN_REQ;
            end else if (status.last) begin
               state_in = ST_TAIL_RD1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TAIL_RD1: begin
            cmd.tail_rd1 = 1'b1;
            state_in     = ST_TAIL_RD2;
         end
         ST_TAIL_RD2: begin
            cmd.tail_rd2 = 1'b1;
            state_in     = ST_TAIL_FIN;
         end
         ST_TAIL_FIN: begin
            if (status.out_free) begin
               cmd.tail_fin = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/upn_datapath.sv
`timescale 1ns / 1ps
// datapath of the url path normalizer: path store, positions and result register
module upn_datapath
   import upn_pkg::*;
#(
   parameter int PATH_BYTES = PATH_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [BYTE_W-1:0] req_path_byte,
   input  logic              req_last_of_path,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ADDR_W-1:0] rsp_write_address,
   output logic [BYTE_W-1:0] rsp_write_byte,
   output logic              rsp_done_res,
   output logic [LEN_W-1:0]  rsp_resolved_length,
   output logic [ERR_W-1:0]  rsp_error_code
);

   localparam int AW = $clog2(PATH_BYTES);
   localparam int PW = AW + 1;
   localparam int OW = (PW > ADDR_W) ? PW : ADDR_W;
   localparam logic [PW-1:0] POS_LIMIT = PW'(PATH_BYTES - 1);
   localparam logic [PW-1:0] POS_ONE   = PW'(1);
   localparam logic [PW-1:0] POS_TWO   = PW'(2);
   localparam logic [PW-1:0] POS_THREE = PW'(3);

   // path store
   logic [BYTE_W-1:0] mem [PATH_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [AW-1:0]     rd_idx;
   logic              wr_en;
   logic [AW-1:0]     wr_idx;
   logic [BYTE_W-1:0] wr_data;

   // path state
   logic [PW-1:0]       wp_ff, wp_in;
   logic [PW-1:0]       ls_ff, ls_in;
   logic [2*BYTE_W-1:0] recent_ff, recent_in;
   logic                in_path_ff, in_path_in;
   err_type             err_ff, err_in;
   logic [PW-1:0]       scan_ptr_ff, scan_ptr_in;
   logic                dot1_ff, dot1_in;
   logic [BYTE_W-1:0]   byte_ff;
   logic                last_ff;

   // result register
   logic              valid_ff, valid_in;
   logic              out_load;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [BYTE_W-1:0] obyte_ff, obyte_in;
   logic              done_ff, done_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   err_type           oerr_ff, oerr_in;

   // helpers
   logic          dotdot_hit;
   logic          scan_hit;
   logic          out_free;
   logic [PW-1:0] tail_len;
   logic          trim;
   logic [PW-1:0] final_pos;
   logic [OW-1:0] wp_ext;
   logic [OW-1:0] final_ext;

   assign out_free   = !valid_ff || !rsp_stall;
   assign dotdot_hit = (recent_ff == PAIR_DOTDOT) && ((ls_ff + POS_THREE) == wp_ff);
   assign scan_hit   = (scan_ptr_ff == '0) || (rd_data_ff == CH_SLASH);
   assign tail_len   = wp_ff - ls_ff;
   assign trim       = ((tail_len == POS_THREE) && dot1_ff && (rd_data_ff == CH_DOT)) ||
                       ((tail_len == POS_TWO) && dot1_ff);
   assign final_pos  = trim ? (ls_ff + POS_ONE) : wp_ff;
   assign wp_ext     = OW'(wp_ff);
   assign final_ext  = OW'(final_pos);

   // status word toward the controller
   always_comb begin
      status.out_free  = out_free;
      status.need_scan = in_path_ff && (err_ff == ERR_NONE) && (byte_ff == CH_SLASH) &&
                         dotdot_hit && (ls_ff != '0);
      status.last      = last_ff;
      status.scan_hit  = scan_hit;
   end

   // read address selection; the second character after the slash stays
   // addressed while the terminator word waits
   always_comb begin
      if (cmd.scan_rd) begin
         rd_idx = scan_ptr_ff[AW-1:0];
      end else if (cmd.tail_rd1) begin
         rd_idx = ls_ff[AW-1:0] + AW'(1);
      end else begin
         rd_idx = ls_ff[AW-1:0] + AW'(2);
      end
   end

   // store write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   // per-byte update, backward scan and end of path
   always_comb begin
      wp_in       = wp_ff;
      ls_in       = ls_ff;
      recent_in   = recent_ff;
      in_path_in  = in_path_ff;
      err_in      = err_ff;
      scan_ptr_in = scan_ptr_ff;
      dot1_in     = dot1_ff;
      wr_en       = 1'b0;
      wr_idx      = wp_ff[AW-1:0];
      wr_data     = byte_ff;
      out_load    = 1'b0;
      addr_in     = wp_ext[ADDR_W-1:0];
      obyte_in    = byte_ff;
      done_in     = 1'b0;
      len_in      = '0;
      oerr_in     = ERR_NONE;

      if (cmd.step) begin
         if (!in_path_ff) begin
            // first byte of a path must be a slash
            in_path_in = 1'b1;
            if (byte_ff != CH_SLASH) begin
               err_in = ERR_NO_SLASH;
            end else begin
               wr_en    = 1'b1;
               wr_idx   = '0;
               out_load = 1'b1;
               addr_in  = '0;
            end
         end else if (err_ff == ERR_NONE) begin
            if (byte_ff == CH_SLASH) begin
               if (dotdot_hit) begin
                  // back up; at the root there is nothing to scan
                  if (ls_ff == '0) begin
                     ls_in = '0;
                     wp_in = POS_ONE;
                  end else begin
                     scan_ptr_in = ls_ff - POS_ONE;
                  end
               end else if (recent_ff == PAIR_SLASHDOT) begin
                  if (wp_ff > POS_ONE) begin
                     wp_in = wp_ff - POS_ONE;
                  end
               end else if ((ls_ff + POS_ONE) != wp_ff) begin
                  if (wp_ff >= POS_LIMIT) begin
                     err_in = ERR_TOO_LONG;
                  end else begin
                     ls_in    = wp_ff;
                     wr_en    = 1'b1;
                     out_load = 1'b1;
                     wp_in    = wp_ff + POS_ONE;
                  end
               end
            end else begin
               if (wp_ff >= POS_LIMIT) begin
                  err_in = ERR_TOO_LONG;
               end else begin
                  wr_en    = 1'b1;
                  out_load = 1'b1;
                  wp_in    = wp_ff + POS_ONE;
               end
            end
            recent_in = {recent_ff[BYTE_W-1:0], byte_ff};
         end
      end

      // one step of the search for the previous slash
      if (cmd.scan_chk) begin
         if (scan_hit) begin
            ls_in = scan_ptr_ff;
            wp_in = scan_ptr_ff + POS_ONE;
         end else begin
            scan_ptr_in = scan_ptr_ff - POS_ONE;
         end
      end

      // first character after the last slash
      if (cmd.tail_rd2) begin
         dot1_in = (rd_data_ff == CH_DOT);
      end

      // terminator word and restart
      if (cmd.tail_fin) begin
         out_load = 1'b1;
         done_in  = 1'b1;
         obyte_in = '0;
         if (err_ff != ERR_NONE) begin
            addr_in = '0;
            oerr_in = err_ff;
         end else begin
            wr_en   = 1'b1;
            wr_idx  = final_pos[AW-1:0];
            wr_data = '0;
            addr_in = final_ext[ADDR_W-1:0];
            len_in  = final_ext[LEN_W-1:0];
         end
         wp_in      = POS_ONE;
         ls_in      = '0;
         recent_in  = RECENT_RESET;
         in_path_in = 1'b0;
         err_in     = ERR_NONE;
      end
   end

   assign valid_in = out_load ? 1'b1 : (valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= POS_ONE;
         ls_ff      <= '0;
         recent_ff  <= RECENT_RESET;
         in_path_ff <= 1'b0;
         err_ff     <= ERR_NONE;
         valid_ff   <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         ls_ff      <= ls_in;
         recent_ff  <= recent_in;
         in_path_ff <= in_path_in;
         err_ff     <= err_in;
         valid_ff   <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_ptr_ff <= scan_ptr_in;
      dot1_ff     <= dot1_in;
      if (cmd.load) begin
         byte_ff <= req_path_byte;
         last_ff <= req_last_of_path;
      end
      if (out_load) begin
         addr_ff  <= addr_in;
         obyte_ff <= obyte_in;
         done_ff  <= done_in;
         len_ff   <= len_in;
         oerr_ff  <= oerr_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_write_address   = addr_ff;
   assign rsp_write_byte      = obyte_ff;
   assign rsp_done_res        = done_ff;
   assign rsp_resolved_length = len_ff;
   assign rsp_error_code      = oerr_ff;

endmodule

// File: rtl/url_path_normalizer.sv
`timescale 1ns / 1ps
// top level of the url path normalizer
//
// Takes a URL path one byte per input word, the first byte being '/', and
// rewrites it in a PATH_BYTES deep path store with repeated slashes, "." and
// ".." segments removed (".." never climbs above the root). Every store write
// leaves as one result word (address, byte); the byte marked last adds a
// terminator word with done_res set and the resolved length, or with an error
// code for a missing leading slash or an overlong path. One byte is taken at a
// time: a plain byte is loaded and then stepped, a ".." segment adds a store read
// and a check for each store entry scanned back toward the previous slash (one
// read of the single store read port per step), and the last byte adds the
// TAIL_RD1, TAIL_RD2 and TAIL_FIN states for the trailing-segment check. A
// finished word waits in the result register while the next byte is taken in.
module url_path_normalizer
   import upn_pkg::*;
#(
   parameter int PATH_BYTES = PATH_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_path_byte,
   input  logic              req_last_of_path,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ADDR_W-1:0] rsp_write_address,
   output logic [BYTE_W-1:0] rsp_write_byte,
   output logic              rsp_done_res,
   output logic [LEN_W-1:0]  rsp_resolved_length,
   output logic [ERR_W-1:0]  rsp_error_code
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   upn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // store, positions and result register
   upn_datapath #(
      .PATH_BYTES (PATH_BYTES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_path_byte       (req_path_byte),
      .req_last_of_path    (req_last_of_path),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_write_address   (rsp_write_address),
      .rsp_write_byte      (rsp_write_byte),
      .rsp_done_res        (rsp_done_res),
      .rsp_resolved_length (rsp_resolved_length),
      .rsp_error_code      (rsp_error_code)
   );

endmodule

// File: sim/url_path_normalizer_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the url path normalizer
module url_path_normalizer_test;
   import upn_pkg::*;

   localparam int RANDOM_WORDS  = 1700;
   localparam int QUIET_WORDS   = 150;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 32;
   localparam int SHOWN_ERRORS  = 10;
   localparam int DEEP_FILL     = 280;

   // one store write as carried by a result word
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
      logic              done;
      logic [LEN_W-1:0]  len;
      logic [ERR_W-1:0]  err;
   } store_write_type;

   // predicts the store writes of each path and checks result words in order
   class path_scoreboard;
      logic [BYTE_W-1:0] store [PATH_BYTES_DEF];
      int unsigned       wpos;
      int unsigned       slash_pos;
      logic [15:0]       recent;
      bit                in_path;
      err_type           err_state;
      store_write_type   pending [$];
      int                failures;

      function new();
         foreach (store[i]) store[i] = '0;
         failures = 0;
         restart();
      endfunction

      function void restart();
         wpos      = 1;
         slash_pos = 0;
         recent    = RECENT_RESET;
         in_path   = 1'b0;
         err_state = ERR_NONE;
      endfunction

      function void add(int unsigned addr, logic [BYTE_W-1:0] data, logic done,
                        int unsigned len, logic [ERR_W-1:0] err);
         store_write_type w;
         w.addr = addr[ADDR_W-1:0];
         w.data = data;
         w.done = done;
         w.len  = len[LEN_W-1:0];
         w.err  = err;
         pending.push_back(w);
      endfunction

      function void flag(string what);
         failures++;
         if (failures <= SHOWN_ERRORS) $display("mismatch: %s", what);
      endfunction

      // one accepted path byte
      function void note_word(logic [BYTE_W-1:0] b, logic last);
         int unsigned p;
         int unsigned d;
         if (!in_path) begin
            in_path = 1'b1;
            if (b != CH_SLASH) begin
               err_state = ERR_NO_SLASH;
            end else begin
               store[0] = CH_SLASH;
               add(0, CH_SLASH, 1'b0, 0, ERR_NONE);
            end
         end else if (err_state == ERR_NONE) begin
            if (b == CH_SLASH) begin
               if (recent == PAIR_DOTDOT && slash_pos + 3 == wpos) begin
                  // dot-dot segment: back up past the previous slash, stop at root
                  p = 0;
                  if (slash_pos > 0) begin
                     p = slash_pos - 1;
                     while (p > 0 && store[p] != CH_SLASH) p--;
                  end
                  slash_pos = p;
                  wpos      = p + 1;
               end else if (recent == PAIR_SLASHDOT) begin
                  if (wpos > 1) wpos--;
               end else if (slash_pos + 1 != wpos) begin
                  if (wpos >= PATH_BYTES_DEF - 1) begin
                     err_state = ERR_TOO_LONG;
                  end else begin
                     slash_pos   = wpos;
                     store[wpos] = CH_SLASH;
                     add(wpos, CH_SLASH, 1'b0, 0, ERR_NONE);
                     wpos++;
                  end
               end
            end else begin
               if (wpos >= PATH_BYTES_DEF - 1) begin
                  err_state = ERR_TOO_LONG;
               end else begin
                  store[wpos] = b;
                  add(wpos, b, 1'b0, 0, ERR_NONE);
                  wpos++;
               end
            end
            recent = {recent[7:0], b};
         end

         // end of path: drop a trailing dot or dot-dot, then terminate
         if (last) begin
            if (err_state != ERR_NONE) begin
               add(0, 8'h00, 1'b1, 0, err_state);
            end else begin
               d = wpos - slash_pos;
               if ((d == 3 && store[slash_pos + 1] == CH_DOT &&
                    store[slash_pos + 2] == CH_DOT) ||
                   (d == 2 && store[slash_pos + 1] == CH_DOT))
                  wpos = slash_pos + 1;
               store[wpos] = 8'h00;
               add(wpos, 8'h00, 1'b1, wpos, ERR_NONE);
            end
            restart();
         end
      endfunction

      // one accepted result word
      function void check_word(store_write_type got);
         store_write_type want;
         if (pending.size() == 0) begin
            flag($sformatf("unexpected word addr %0d byte %02h done %0b len %0d err %0d",
                           got.addr, got.data, got.done, got.len, got.err));
            return;
         end
         want = pending.pop_front();
         if (got.addr != want.addr || got.data != want.data || got.done != want.done ||
             got.len != want.len || got.err != want.err)
            flag($sformatf({"expected addr %0d byte %02h done %0b len %0d err %0d, ",
                            "got addr %0d byte %02h done %0b len %0d err %0d"},
                           want.addr, want.data, want.done, want.len, want.err,
                           got.addr, got.data, got.done, got.len, got.err));
      endfunction

      function void close();
         foreach (pending[i])
            flag($sformatf("missing word addr %0d byte %02h done %0b",
                           pending[i].addr, pending[i].data, pending[i].done));
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [BYTE_W-1:0] req_path_byte;
   logic              req_last_of_path;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [ADDR_W-1:0] rsp_write_address;
   logic [BYTE_W-1:0] rsp_write_byte;
   logic              rsp_done_res;
   logic [LEN_W-1:0]  rsp_resolved_length;
   logic [ERR_W-1:0]  rsp_error_code;

   path_scoreboard    sb = new();
   logic [BYTE_W-1:0] path [$];
   int unsigned       sent = 0;
   bit                quiet = 1'b0;

   url_path_normalizer i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_path_byte       (req_path_byte),
      .req_last_of_path    (req_last_of_path),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_write_address   (rsp_write_address),
      .rsp_write_byte      (rsp_write_byte),
      .rsp_done_res        (rsp_done_res),
      .rsp_resolved_length (rsp_resolved_length),
      .rsp_error_code      (rsp_error_code)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watch both channels at the clock edge
   always @(posedge clock) begin : monitor
      store_write_type seen;
      if (!reset && req_valid && !req_stall) sb.note_word(req_path_byte, req_last_of_path);
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.addr = rsp_write_address;
         seen.data = rsp_write_byte;
         seen.done = rsp_done_res;
         seen.len  = rsp_resolved_length;
         seen.err  = rsp_error_code;
         sb.check_word(seen);
      end
   end

   // result side: stall bursts, calm stretches, none in the quiet tail
   initial begin : rsp_side
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!quiet) begin
            case ($urandom_range(0, 7))
               0, 1: begin
                  rsp_stall <= 1'b1;
                  repeat ($urandom_range(1, 8)) @(posedge clock);
                  rsp_stall <= 1'b0;
               end
               2: repeat ($urandom_range(20, 60)) @(posedge clock);
               default: ;
            endcase
         end
      end
   end

   // run limit
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   // offer one word and hold it until taken
   task automatic send_word(input logic [BYTE_W-1:0] b, input logic last, input bit gaps);
      if (gaps && !quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_path_byte    <= b;
      req_last_of_path <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic send_path(input bit gaps);
      foreach (path[i]) send_word(path[i], i == path.size() - 1, gaps);
   endtask

   // hold off the sender until every pending word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic void append_text(string t);
      for (int k = 0; k < t.len(); k++) path.push_back(t[k]);
   endfunction

   // mostly letters, some dots, now and then any byte but a slash
   function automatic logic [BYTE_W-1:0] name_char();
      logic [BYTE_W-1:0] c;
      case ($urandom_range(0, 9))
         0, 1: c = CH_DOT;
         2: begin
            c = BYTE_W'($urandom_range(0, 255));
            if (c == CH_SLASH) c = 8'h00;
         end
         default: c = BYTE_W'($urandom_range(8'h61, 8'h7A));
      endcase
      return c;
   endfunction

   // any byte but a slash or a dot, for long plain segments
   function automatic logic [BYTE_W-1:0] fill_char();
      logic [BYTE_W-1:0] c;
      c = BYTE_W'($urandom_range(0, 255));
      if (c == CH_SLASH || c == CH_DOT) c = 8'h5F;
      return c;
   endfunction

   // well-formed path of random segments: empty, dot, dot-dot or names
   function automatic void build_segments();
      int unsigned segs;
      path.delete();
      path.push_back(CH_SLASH);
      segs = $urandom_range(0, 6);
      for (int s = 0; s < segs; s++) begin
         if (s > 0) path.push_back(CH_SLASH);
         case ($urandom_range(0, 7))
            0: ;
            1: path.push_back(CH_DOT);
            2, 3: append_text("..");
            default: repeat ($urandom_range(1, 6)) path.push_back(name_char());
         endcase
      end
      if ($urandom_range(0, 3) == 0) path.push_back(CH_SLASH);
   endfunction

   // raw bytes, optionally behind a leading slash
   function automatic void build_noise(input bit rooted);
      path.delete();
      repeat ($urandom_range(1, rooted ? 20 : 10))
         path.push_back(BYTE_W'($urandom_range(0, 255)));
      if (rooted) path[0] = CH_SLASH;
   endfunction

   // fills the store to its end, then overflows on a slash or a plain byte
   function automatic void build_overlong();
      path.delete();
      path.push_back(CH_SLASH);
      repeat (PATH_BYTES_DEF - 2) path.push_back(fill_char());
      path.push_back($urandom_range(0, 1) ? CH_SLASH : fill_char());
      append_text("b/c");
   endfunction

   // second dot-dot scans back across one long segment
   function automatic void build_deep_scan();
      path.delete();
      path.push_back(CH_SLASH);
      repeat (DEEP_FILL) path.push_back(fill_char());
      append_text("/x/../../y");
   endfunction

   initial begin : stimulus
      int unsigned goal;
      int unsigned paths;
      int unsigned pick;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_path_byte    <= '0;
      req_last_of_path <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: root alone, missing slash, all segment kinds, root climb, odd bytes
      path.delete();
      append_text("/");
      send_path(1'b1);
      path.delete();
      append_text("x");
      send_path(1'b1);
      path.delete();
      append_text("/a//./b/../..");
      send_path(1'b1);
      path.delete();
      append_text("/../.");
      send_path(1'b1);
      path.delete();
      path.push_back(CH_SLASH);
      path.push_back(8'h00);
      path.push_back(8'hFF);
      path.push_back(8'h80);
      send_path(1'b1);
      wait_drained();

      // random paths, drained every so often
      goal  = sent + RANDOM_WORDS;
      paths = 0;
      while (sent < goal) begin
         if (sent + QUIET_WORDS >= goal) quiet = 1'b1;
         if (paths == 10) begin
            build_overlong();
         end else if (paths == 40) begin
            build_deep_scan();
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 8) build_noise(1'b0);
            else if (pick < 14) build_noise(1'b1);
            else build_segments();
         end
         send_path($urandom_range(0, 4) != 0);
         paths++;
         if (paths % 25 == 0) wait_drained();
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.close();
      if (sb.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/upn_pkg.sv
rtl/upn_ctrl.sv
rtl/upn_datapath.sv
rtl/url_path_normalizer.sv
sim/url_path_normalizer_test.sv
